// ===== src/msb_first_bit_field_reader_top_macros.svh =====
// Assertion macros for the bit field reader checker.
// Included by the checker file only.
`ifndef MSB_FIRST_BIT_FIELD_READER_TOP_MACROS_SVH
`define MSB_FIRST_BIT_FIELD_READER_TOP_MACROS_SVH
// Immediate implication on the same edge.
`define BFR_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// Implication on the following edge.
`define BFR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`endif

// ===== src/bfr_pkg.sv =====
// Shared types and constants for the MSB-first bit field reader.
// No dependencies.
`default_nettype none
package bfr_pkg;
	localparam int StoreBytesDefault = 4096;
	localparam int MaxFieldBitsDefault = 64;

	typedef enum logic [3:0] {
		OP_LOAD = 4'd0, OP_READ = 4'd1, OP_PEEK = 4'd2, OP_SKIP = 4'd3,
		OP_SEEK = 4'd4, OP_ALIGN = 4'd5, OP_UNGET = 4'd6, OP_EXPECT = 4'd7,
		OP_CLR = 4'd8, OP_SET = 4'd9
	} op_t;

	localparam logic [1:0] ORG_ABS = 2'd0;
	localparam logic [1:0] ORG_BEGIN = 2'd1;
	localparam logic [1:0] ORG_CUR = 2'd2;
	localparam logic [1:0] ORG_END = 2'd3;

	localparam logic [1:0] REG_BEGIN = 2'd0;
	localparam logic [1:0] REG_END = 2'd1;

	// Controller to datapath commands.
	typedef struct packed {
		logic capture;   // latch the input item
		logic check;     // evaluate window checks, start a fetch
		logic fetch;     // step the byte fetch
		logic div_start; // start align division
		logic div_step;  // one quotient bit
		logic commit;    // write architectural state
	} bfr_cmd_t;

	// Datapath to controller status.
	typedef struct packed {
		logic need_fetch;
		logic fetch_done;
		logic need_div;
		logic div_done;
	} bfr_stat_t;
endpackage
`default_nettype wire

// ===== src/bfr_ctrl.sv =====
// Controller state machine for the bit field reader.
// Depends on bfr_pkg.
`default_nettype none
module bfr_ctrl import bfr_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      start,
	output logic           busy,
	output logic           done,
	output bfr_cmd_t       cmd,
	input  wire bfr_stat_t stat
);
	typedef enum logic [5:0] {
		S_IDLE = 6'b000001, S_CHECK = 6'b000010, S_FETCH = 6'b000100,
		S_DIV = 6'b001000, S_COMMIT = 6'b010000, S_DONE = 6'b100000
	} state_t;

	state_t state_q, state_d;

	// Next-state and command decode.
	always_comb begin
		state_d = state_q;
		cmd = '0;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.capture = 1'b1;
					state_d = S_CHECK;
				end
			end
			S_CHECK: begin
				cmd.check = 1'b1;
				if (stat.need_fetch) begin
					state_d = S_FETCH;
				end else if (stat.need_div) begin
					cmd.div_start = 1'b1;
					state_d = S_DIV;
				end else begin
					state_d = S_COMMIT;
				end
			end
			S_FETCH: begin
				cmd.fetch = 1'b1;
				if (stat.fetch_done) state_d = S_COMMIT;
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (stat.div_done) state_d = S_COMMIT;
			end
			S_COMMIT: begin
				cmd.commit = 1'b1;
				state_d = S_DONE;
			end
			S_DONE: state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_d;
	end

	assign busy = (state_q != S_IDLE);
	assign done = (state_q == S_DONE);
endmodule
`default_nettype wire

// ===== src/bfr_dp.sv =====
// Datapath for the bit field reader: byte store, fetch shifter, divider, state.
// Depends on bfr_pkg.
`default_nettype none
module bfr_dp import bfr_pkg::*; #(
	parameter int STORE_BYTES = StoreBytesDefault,
	parameter int MAX_FIELD_BITS = MaxFieldBitsDefault
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire bfr_cmd_t    cmd,
	output bfr_stat_t        stat,
	input  wire logic [3:0]  operation,
	input  wire logic [11:0] byte_address,
	input  wire logic [7:0]  byte_data,
	input  wire logic [15:0] bit_count,
	input  wire logic signed [16:0] offset,
	input  wire logic [1:0]  seek_origin,
	input  wire logic [15:0] align_unit,
	input  wire logic        expected_bit,
	input  wire logic [2:0]  new_status,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [15:0] cfg_data,
	output logic [63:0]      value,
	output logic [15:0]      got_count,
	output logic [15:0]      position,
	output logic [2:0]       status
);
	localparam int AW = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;
	localparam int NB = (MAX_FIELD_BITS + 14) / 8 + 1;
	localparam int CW = $clog2(NB + 1);

	// Configuration registers.
	logic [15:0] begin_q, end_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			begin_q <= '0;
			end_q <= 16'd32768;
		end else if (cfg_we) begin
			if (cfg_index == REG_BEGIN) begin_q <= cfg_data;
			else if (cfg_index == REG_END) end_q <= cfg_data;
		end
	end

	// Captured item.
	logic [3:0]  op_q;
	logic [11:0] addr_q;
	logic [7:0]  data_q;
	logic [15:0] cnt_q, unit_q;
	logic signed [16:0] off_q;
	logic [1:0]  org_q;
	logic        want_q;
	logic [2:0]  nst_q;
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q <= operation; addr_q <= byte_address; data_q <= byte_data;
			cnt_q <= bit_count; off_q <= offset; org_q <= seek_origin;
			unit_q <= align_unit; want_q <= expected_bit; nst_q <= new_status;
		end
	end

	// Architectural state.
	logic [15:0] pos_q, lcnt_q;
	logic [63:0] lval_q;
	logic [2:0]  st_q;

	// Field width for reads and the window check.
	logic        is_rd;
	logic [15:0] n;
	logic        rd_ok;
	logic [16:0] room;
	always_comb begin
		is_rd = (op_q == OP_READ) || (op_q == OP_PEEK) || (op_q == OP_EXPECT);
		n = (op_q == OP_READ) ? cnt_q : 16'd1;
		room = {1'b0, end_q} - {1'b0, pos_q};
		rd_ok = (n == 16'd0) ||
			((n <= 16'(MAX_FIELD_BITS)) && (pos_q <= end_q) && ({1'b0, n} <= room));
	end

	// Byte store, read at a running address.
	logic [7:0]    mem [STORE_BYTES];
	logic [7:0]    rdata_s1;
	logic [AW-1:0] raddr;
	logic [CW-1:0] fcnt_q;
	logic [12:0]   bidx_q;
	logic          rvalid_s1;
	logic [NB*8-1:0] win_q;

	assign raddr = AW'(bidx_q + 13'(fcnt_q));
	always_ff @(posedge clk) begin
		if (cmd.commit && op_q == OP_LOAD && {4'd0, addr_q} < 16'(STORE_BYTES))
			mem[addr_q[AW-1:0]] <= data_q;
		rdata_s1 <= mem[raddr];
	end

	// Fetch sequencer: one byte per cycle into a window register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fcnt_q <= '0;
			rvalid_s1 <= 1'b0;
		end else if (cmd.check) begin
			fcnt_q <= '0;
			rvalid_s1 <= 1'b0;
		end else if (cmd.fetch) begin
			if (fcnt_q != CW'(NB)) fcnt_q <= fcnt_q + 1'b1;
			rvalid_s1 <= (fcnt_q != CW'(NB));
		end
	end
	always_ff @(posedge clk) begin
		if (cmd.check) bidx_q <= pos_q[15:3];
		if (cmd.fetch && rvalid_s1) win_q <= {win_q[NB*8-9:0], rdata_s1};
	end

	// Field extraction from the window.
	logic [NB*8-1:0] sh;
	logic [63:0]     field;
	always_comb begin
		sh = win_q << pos_q[2:0];
		field = 64'(sh[NB*8-1 -: 64] >> (7'd64 - 7'(n)));
		if (n == 16'd0) field = '0;
	end

	// Align divider: restoring, one quotient bit per cycle.
	logic [16:0] dividend;
	logic [15:0] quo_q;
	logic [16:0] rem_q;
	logic [16:0] dvd_q;
	logic [4:0]  dstep_q;
	logic [16:0] rtry;
	logic        align_go;
	assign align_go = (st_q == 3'd0) && (unit_q != 16'd0) &&
		(pos_q >= begin_q) && (pos_q <= end_q);
	assign dividend = {1'b0, pos_q} + {1'b0, unit_q} - 17'd1;
	assign rtry = {rem_q[15:0], dvd_q[16]};
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) dstep_q <= '0;
		else if (cmd.div_start) dstep_q <= 5'd17;
		else if (cmd.div_step && dstep_q != 5'd0) dstep_q <= dstep_q - 5'd1;
	end
	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			dvd_q <= dividend; rem_q <= '0; quo_q <= '0;
		end else if (cmd.div_step && dstep_q != 5'd0) begin
			dvd_q <= {dvd_q[15:0], 1'b0};
			if (rtry >= {1'b0, unit_q}) begin
				rem_q <= rtry - {1'b0, unit_q};
				quo_q <= {quo_q[14:0], 1'b1};
			end else begin
				rem_q <= rtry;
				quo_q <= {quo_q[14:0], 1'b0};
			end
		end
	end
	// Product quotient * unit; target stays in 32 bits.
	logic [31:0] atgt;
	assign atgt = quo_q * unit_q;

	assign stat.need_fetch = is_rd && rd_ok && (n != 16'd0);
	assign stat.fetch_done = (fcnt_q == CW'(NB)) && !rvalid_s1;
	assign stat.need_div = (op_q == OP_ALIGN) && align_go;
	assign stat.div_done = (dstep_q == 5'd0);

	// Seek and relative targets.
	logic signed [18:0] base, tgt;
	logic [16:0] skt;
	logic        tgt_in, skt_in, ung_in, at_in, adv_in;
	logic [16:0] adv;
	always_comb begin
		unique case (org_q)
			ORG_BEGIN: base = 19'(begin_q);
			ORG_CUR:   base = 19'(pos_q);
			ORG_END:   base = 19'(end_q);
			default:   base = '0;
		endcase
		tgt = base + 19'(off_q);
		tgt_in = (tgt >= 19'(begin_q)) && (tgt <= 19'(end_q));
		skt = {1'b0, pos_q} + {1'b0, cnt_q};
		skt_in = (skt >= {1'b0, begin_q}) && (skt <= {1'b0, end_q});
		adv = {1'b0, pos_q} + {1'b0, n};
		adv_in = (adv >= {1'b0, begin_q}) && (adv <= {1'b0, end_q});
		ung_in = (pos_q != 16'd0) && ((pos_q - 16'd1) >= begin_q) &&
			((pos_q - 16'd1) <= end_q);
		at_in = (atgt >= 32'(begin_q)) && (atgt <= 32'(end_q));
	end

	// Commit of the operation.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0; lcnt_q <= '0; lval_q <= '0; st_q <= '0;
		end else if (cmd.commit) begin
			unique case (op_q)
				OP_READ, OP_EXPECT: begin
					if (rd_ok) begin
						lval_q <= field;
						lcnt_q <= n;
						if (n != 16'd0 && adv_in) pos_q <= adv[15:0];
						if (op_q == OP_EXPECT && {63'd0, want_q} != field)
							st_q[0] <= 1'b1;
					end else begin
						st_q[2:1] <= 2'b11;
						lval_q <= '0;
						lcnt_q <= '0;
						if (op_q == OP_EXPECT && want_q) st_q[0] <= 1'b1;
					end
				end
				OP_PEEK: begin
					if (rd_ok) begin
						lval_q <= field; lcnt_q <= 16'd1;
					end else begin
						st_q[2] <= 1'b1; lcnt_q <= '0;
					end
				end
				OP_SKIP: begin
					if (skt_in) begin
						pos_q <= skt[15:0]; lcnt_q <= cnt_q;
					end else begin
						st_q[2] <= 1'b1; lcnt_q <= '0;
					end
				end
				OP_SEEK: begin
					if (tgt_in) pos_q <= tgt[15:0];
					else st_q[1] <= 1'b1;
				end
				OP_ALIGN: begin
					lcnt_q <= '0;
					if (st_q == 3'd0 && unit_q != 16'd0) begin
						if (align_go && at_in) pos_q <= atgt[15:0];
						else st_q[1] <= 1'b1;
					end
				end
				OP_UNGET: begin
					lcnt_q <= '0;
					if (ung_in) pos_q <= pos_q - 16'd1;
					else st_q[1] <= 1'b1;
				end
				OP_CLR: st_q <= nst_q;
				OP_SET: st_q <= st_q | nst_q;
				default: ;
			endcase
		end
	end

	assign value = lval_q;
	assign got_count = lcnt_q;
	assign position = pos_q;
	assign status = st_q;
endmodule
`default_nettype wire

// ===== src/msb_first_bit_field_reader_top.sv =====
// MSB-first bit field reader: load, seek, skip and status items go from check to commit;
// read, peek and expect in range fetch a byte window first (NB = byte window, 10 for 64 bits),
// and align with a usable unit runs the divider first (one quotient bit per cycle in the divider).
// One item at a time; busy is high from acceptance until the result strobe.
// The receiver cannot stall. Reset clears position, status and counts;
// begin_bit resets to 0 and end_bit to 32768; the byte store is not cleared.
`default_nettype none
module msb_first_bit_field_reader_top import bfr_pkg::*; #(
	parameter int STORE_BYTES = StoreBytesDefault,
	parameter int MAX_FIELD_BITS = MaxFieldBitsDefault
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [3:0]  operation,
	input  wire logic [11:0] byte_address,
	input  wire logic [7:0]  byte_data,
	input  wire logic [15:0] bit_count,
	input  wire logic signed [16:0] offset,
	input  wire logic [1:0]  seek_origin,
	input  wire logic [15:0] align_unit,
	input  wire logic        expected_bit,
	input  wire logic [2:0]  new_status,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [15:0] cfg_data,
	output logic             done,
	output logic [63:0]      value,
	output logic [15:0]      got_count,
	output logic [15:0]      position,
	output logic             eof_flag,
	output logic             fail_flag,
	output logic             bad_flag
);
	bfr_cmd_t  cmd;
	bfr_stat_t stat;
	logic [2:0] st;

	assign cfg_ready = 1'b1;

	bfr_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .done(done),
		.cmd(cmd), .stat(stat)
	);

	bfr_dp #(.STORE_BYTES(STORE_BYTES), .MAX_FIELD_BITS(MAX_FIELD_BITS)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .stat(stat),
		.operation(operation), .byte_address(byte_address), .byte_data(byte_data),
		.bit_count(bit_count), .offset(offset), .seek_origin(seek_origin),
		.align_unit(align_unit), .expected_bit(expected_bit),
		.new_status(new_status), .cfg_we(cfg_valid & cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data), .value(value),
		.got_count(got_count), .position(position), .status(st)
	);

	assign bad_flag = st[0];
	assign fail_flag = st[1];
	assign eof_flag = st[2];
endmodule
`default_nettype wire

// ===== src/bfr_checker.sv =====
// Port-level checker for the bit field reader, bound to the top level.
// Depends on msb_first_bit_field_reader_top_macros.svh.
`default_nettype none
`include "msb_first_bit_field_reader_top_macros.svh"
module bfr_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic busy,
	input wire logic done,
	input wire logic [15:0] position
);
	// A result only appears while an item is in flight.
	`BFR_ASSERT_NOW(a_done_busy, clk, arst_n, done, busy)
	// An accepted item makes the block busy.
	`BFR_ASSERT_NEXT(a_accept_busy, clk, arst_n, start && !busy, busy)
	// The block is free right after a result.
	`BFR_ASSERT_NEXT(a_done_free, clk, arst_n, done, !busy)
	// Position does not move while idle.
	`BFR_ASSERT_NEXT(a_pos_idle, clk, arst_n, !busy && !start, $stable(position))
endmodule

bind msb_first_bit_field_reader_top bfr_checker u_bfr_checker (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .done(done),
	.position(position)
);
`default_nettype wire

// ===== verif/msb_first_bit_field_reader_checker.sv =====
// Checker for the MSB-first bit field reader: predicts each result from accepted items
// and register writes, then compares every strobed result field by field.
// Depends on bfr_pkg.
module msb_first_bit_field_reader_checker import bfr_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic              busy,
	input  logic [3:0]        operation,
	input  logic [11:0]       byte_address,
	input  logic [7:0]        byte_data,
	input  logic [15:0]       bit_count,
	input  logic signed [16:0] offset,
	input  logic [1:0]        seek_origin,
	input  logic [15:0]       align_unit,
	input  logic              expected_bit,
	input  logic [2:0]        new_status,
	input  logic              cfg_valid,
	input  logic              cfg_ready,
	input  logic [1:0]        cfg_index,
	input  logic [15:0]       cfg_data,
	input  logic              done,
	input  logic [63:0]       value,
	input  logic [15:0]       got_count,
	input  logic [15:0]       position,
	input  logic              eof_flag,
	input  logic              fail_flag,
	input  logic              bad_flag,
	output int                mismatches,
	output int                outstanding
);
	localparam logic [2:0] ST_BAD = 3'b001;
	localparam logic [2:0] ST_FAIL = 3'b010;
	localparam logic [2:0] ST_EOF = 3'b100;

	typedef struct packed {
		logic [63:0] value;
		logic [15:0] count;
		logic [15:0] pos;
		logic        eof;
		logic        fail;
		logic        bad;
	} readout_t;

	readout_t pending_readouts[$];
	logic [7:0] byte_copy [0:StoreBytesDefault-1];
	logic [15:0] cur_pos, last_cnt, win_begin, win_end;
	logic [2:0] status;
	logic [63:0] last_val;

	initial begin
		mismatches = 0;
		outstanding = 0;
	end

	function automatic bit in_window(longint p);
		return p >= longint'(win_begin) && p <= longint'(win_end);
	endfunction

	function automatic logic bit_at(int unsigned p);
		int unsigned idx;
		idx = (p >> 3) % StoreBytesDefault;
		return byte_copy[idx][7 - (p & 7)];
	endfunction

	task automatic try_move(input longint p, output bit ok);
		ok = in_window(p);
		if (ok) cur_pos = p[15:0];
	endtask

	// Extracts n bits starting at the current position, optionally advancing.
	task automatic take_field(input int unsigned n, input bit advance, output bit ok,
			output logic [63:0] v);
		bit moved;
		v = '0;
		ok = 1'b1;
		if (n == 0) return;
		if (n > MaxFieldBitsDefault || cur_pos > win_end ||
				n > int'(win_end) - int'(cur_pos)) begin
			ok = 1'b0;
			return;
		end
		for (int unsigned i = 0; i < n; i++) v = {v[62:0], bit_at(cur_pos + i)};
		if (advance) try_move(longint'(cur_pos) + n, moved);
	endtask

	task automatic read_field(input int unsigned n);
		bit ok;
		logic [63:0] v;
		take_field(n, 1'b1, ok, v);
		if (ok) begin
			last_val = v;
			last_cnt = 16'(n);
		end else begin
			status |= ST_FAIL | ST_EOF;
			last_val = '0;
			last_cnt = '0;
		end
	endtask

	// Applies one accepted item to the predicted state and queues its result.
	task automatic advance_reader();
		bit ok;
		logic [63:0] v;
		longint base;
		int unsigned target;
		readout_t r;
		case (operation)
			OP_LOAD: byte_copy[byte_address] = byte_data;
			OP_READ: read_field(bit_count);
			OP_PEEK: begin
				take_field(1, 1'b0, ok, v);
				if (ok) begin
					last_val = v;
					last_cnt = 1;
				end else begin
					status |= ST_EOF;
					last_cnt = '0;
				end
			end
			OP_SKIP: begin
				try_move(longint'(cur_pos) + bit_count, ok);
				if (ok) last_cnt = bit_count;
				else begin
					status |= ST_EOF;
					last_cnt = '0;
				end
			end
			OP_SEEK: begin
				case (seek_origin)
					ORG_BEGIN: base = win_begin;
					ORG_CUR: base = cur_pos;
					ORG_END: base = win_end;
					default: base = 0;
				endcase
				try_move(base + longint'(offset), ok);
				if (!ok) status |= ST_FAIL;
			end
			OP_ALIGN: begin
				if (status == 3'b000 && align_unit != 0) begin
					if (!in_window(cur_pos)) status |= ST_FAIL;
					else begin
						target = ((cur_pos + align_unit - 1) / align_unit) * align_unit;
						try_move(target, ok);
						if (!ok) status |= ST_FAIL;
					end
				end
				last_cnt = '0;
			end
			OP_UNGET: begin
				last_cnt = '0;
				try_move(longint'(cur_pos) - 1, ok);
				if (!ok) status |= ST_FAIL;
			end
			OP_EXPECT: begin
				read_field(1);
				if (64'(expected_bit) != last_val) status |= ST_BAD;
			end
			OP_CLR: status = new_status;
			OP_SET: status |= new_status;
			default: ;
		endcase
		r.value = last_val;
		r.count = last_cnt;
		r.pos = cur_pos;
		r.eof = status[2];
		r.fail = status[1];
		r.bad = status[0];
		pending_readouts.push_back(r);
	endtask

	task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
		$display("mismatch in %s: got %0h, expected %0h", what, got, want);
		mismatches++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		readout_t e;
		if (!arst_n) begin
			cur_pos = '0;
			status = '0;
			last_cnt = '0;
			last_val = '0;
			win_begin = 16'd0;
			win_end = 16'd32768;
			pending_readouts.delete();
		end else begin
			// Results come strictly after their item, so compare before queueing.
			if (done) begin
				if (pending_readouts.size() == 0) report("unexpected result", value, 0);
				else begin
					e = pending_readouts.pop_front();
					if (value !== e.value) report("value", value, e.value);
					if (got_count !== e.count) report("got_count", got_count, e.count);
					if (position !== e.pos) report("position", position, e.pos);
					if (eof_flag !== e.eof) report("eof_flag", eof_flag, e.eof);
					if (fail_flag !== e.fail) report("fail_flag", fail_flag, e.fail);
					if (bad_flag !== e.bad) report("bad_flag", bad_flag, e.bad);
				end
			end
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == REG_BEGIN) win_begin = cfg_data;
				else if (cfg_index == REG_END) win_end = cfg_data;
			end
			if (start && !busy) advance_reader();
		end
		outstanding = pending_readouts.size();
	end
endmodule

// ===== verif/msb_first_bit_field_reader_top_tb.sv =====
// Testbench top for the MSB-first bit field reader: fills the bottom and top of the byte store, runs directed
// and random items over several bit windows, and gives the verdict from the checker.
// Depends on bfr_pkg, msb_first_bit_field_reader_top and the checker module.
module msb_first_bit_field_reader_top_tb;
	import bfr_pkg::*;

	localparam logic [3:0] OP_UNUSED_LAST = 4'd15;
	localparam int IDLE_LIMIT = 3000;
	localparam int SETTLE_CYCLES = 40;
	localparam int FILL_BYTES = 256;
	localparam int RANDOM_PER_PHASE = 80;

	logic clk, arst_n, start, busy, cfg_valid, cfg_ready, done;
	logic [3:0] operation;
	logic [11:0] byte_address;
	logic [7:0] byte_data;
	logic [15:0] bit_count, align_unit, cfg_data, got_count, position;
	logic signed [16:0] offset;
	logic [1:0] seek_origin, cfg_index;
	logic expected_bit, eof_flag, fail_flag, bad_flag;
	logic [2:0] new_status;
	logic [63:0] value;
	int mismatches, outstanding, idle_cycles;
	bit idling_on;
	int win_lo, win_hi;

	msb_first_bit_field_reader_top dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .operation(operation),
		.byte_address(byte_address), .byte_data(byte_data), .bit_count(bit_count),
		.offset(offset), .seek_origin(seek_origin), .align_unit(align_unit),
		.expected_bit(expected_bit), .new_status(new_status), .cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data), .done(done),
		.value(value), .got_count(got_count), .position(position), .eof_flag(eof_flag),
		.fail_flag(fail_flag), .bad_flag(bad_flag)
	);

	msb_first_bit_field_reader_checker u_checker (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .operation(operation),
		.byte_address(byte_address), .byte_data(byte_data), .bit_count(bit_count),
		.offset(offset), .seek_origin(seek_origin), .align_unit(align_unit),
		.expected_bit(expected_bit), .new_status(new_status), .cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data), .done(done),
		.value(value), .got_count(got_count), .position(position), .eof_flag(eof_flag),
		.fail_flag(fail_flag), .bad_flag(bad_flag), .mismatches(mismatches),
		.outstanding(outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Watchdog: ends the run when nothing moves on any channel for too long.
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done || (cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// Presents one item, with an optional random gap first, and waits for acceptance.
	task automatic send_item(input logic [3:0] op, input logic [11:0] a, input logic [7:0] d,
			input logic [15:0] n, input logic signed [16:0] o, input logic [1:0] org,
			input logic [15:0] u, input logic w, input logic [2:0] s);
		if (idling_on && $urandom_range(0, 3) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		operation <= op;
		byte_address <= a;
		byte_data <= d;
		bit_count <= n;
		offset <= o;
		seek_origin <= org;
		align_unit <= u;
		expected_bit <= w;
		new_status <= s;
		start <= 1'b1;
		do @(posedge clk); while (busy);
	endtask

	// Directed item with random filler in the fields the operation ignores.
	task automatic op_item(input logic [3:0] op, input logic [15:0] n, input int o,
			input logic [1:0] org, input logic [15:0] u, input logic w, input logic [2:0] s);
		send_item(op, 12'($urandom), 8'($urandom), n, 17'(o), org, u, w, s);
	endtask

	function automatic logic [15:0] pick_width();
		int r;
		r = $urandom_range(0, 19);
		if (r < 16) return 16'($urandom_range(1, 64));
		if (r < 18) return 16'($urandom_range(0, 70));
		return 16'($urandom);
	endfunction

	// Random item, weighted toward reads and positioning inside the window.
	task automatic random_item();
		int r, o;
		logic [15:0] n, u;
		r = $urandom_range(0, 99);
		o = ($urandom_range(0, 1) == 1) ? int'($urandom_range(0, win_hi + 80)) - 40
			: int'($signed(17'($urandom)));
		n = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 200));
		u = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 64));
		if (r < 30) op_item(OP_READ, pick_width(), o, 2'($urandom), u, 1'($urandom),
			3'($urandom));
		else if (r < 38) op_item(OP_PEEK, n, o, 2'($urandom), u, 1'($urandom), 3'($urandom));
		else if (r < 46) op_item(OP_SKIP, n, o, 2'($urandom), u, 1'($urandom), 3'($urandom));
		else if (r < 56) begin
			case ($urandom_range(0, 3))
				0: o = ($urandom_range(0, 1) == 1) ? o : int'($urandom_range(win_lo, win_hi + 2));
				1: o = ($urandom_range(0, 1) == 1) ? o : int'($urandom_range(0, 300)) - 4;
				2: o = ($urandom_range(0, 1) == 1) ? o : int'($urandom_range(0, 400)) - 200;
				default: o = ($urandom_range(0, 1) == 1) ? o : -int'($urandom_range(0, 300));
			endcase
			op_item(OP_SEEK, n, o, 2'(r % 4), u, 1'($urandom), 3'($urandom));
		end
		else if (r < 64) op_item(OP_ALIGN, n, o, 2'($urandom), u, 1'($urandom), 3'($urandom));
		else if (r < 70) op_item(OP_UNGET, n, o, 2'($urandom), u, 1'($urandom), 3'($urandom));
		else if (r < 80) op_item(OP_EXPECT, n, o, 2'($urandom), u, 1'($urandom), 3'($urandom));
		else if (r < 88) op_item(OP_CLR, n, o, 2'($urandom), u, 1'($urandom),
			($urandom_range(0, 3) == 0) ? 3'($urandom) : 3'b000);
		else if (r < 92) op_item(OP_SET, n, o, 2'($urandom), u, 1'($urandom), 3'($urandom));
		else if (r < 97) op_item(OP_LOAD, n, o, 2'($urandom), u, 1'($urandom), 3'($urandom));
		else op_item(4'($urandom_range(OP_SET + 1, OP_UNUSED_LAST)), n, o, 2'($urandom), u,
			1'($urandom), 3'($urandom));
	endtask

	// Register writes happen only with the block idle and all results back.
	task automatic write_reg(input logic [1:0] idx, input logic [15:0] d);
		start <= 1'b0;
		do @(posedge clk); while (outstanding != 0 || busy);
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= d;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	task automatic set_window(input int lo, input int hi);
		write_reg(REG_BEGIN, 16'(lo));
		write_reg(REG_END, 16'(hi));
		win_lo = lo;
		win_hi = hi;
	endtask

	initial begin
		int lo, hi;
		arst_n = 1'b0;
		start = 1'b0;
		operation = OP_LOAD;
		byte_address = '0;
		byte_data = '0;
		bit_count = '0;
		offset = '0;
		seek_origin = ORG_ABS;
		align_unit = '0;
		expected_bit = 1'b0;
		new_status = '0;
		cfg_valid = 1'b0;
		cfg_index = REG_BEGIN;
		cfg_data = '0;
		idle_cycles = 0;
		idling_on = 1'b1;
		win_lo = 0;
		win_hi = 32768;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Fill the bottom and the top of the store. Every window used below only
		// reads bits that land in one of these two regions after address wrap.
		for (int a = 0; a < 2 * FILL_BYTES; a++)
			send_item(OP_LOAD,
				(a < FILL_BYTES) ? 12'(a) : 12'(StoreBytesDefault - 2 * FILL_BYTES + a),
				8'($urandom), 16'($urandom), 17'($urandom),
				2'($urandom), 16'($urandom), 1'($urandom), 3'($urandom));

		// Directed: field width extremes, every operation other than load and the failure paths.
		op_item(OP_READ, 16'd0, 0, ORG_ABS, 16'd1, 1'b0, 3'b000);
		op_item(OP_READ, 16'd64, 0, ORG_ABS, 16'd1, 1'b0, 3'b000);
		op_item(OP_READ, 16'd65, 0, ORG_ABS, 16'd1, 1'b0, 3'b000);
		op_item(OP_CLR, 16'd0, 0, ORG_ABS, 16'd1, 1'b0, 3'b000);
		op_item(OP_PEEK, 16'd0, 0, ORG_ABS, 16'd1, 1'b0, 3'b000);
		op_item(OP_SKIP, 16'd0, 0, ORG_ABS, 16'd1, 1'b0, 3'b000);
		op_item(OP_SKIP, 16'hFFFF, 0, ORG_ABS, 16'd1, 1'b0, 3'b000);
		op_item(OP_SEEK, 16'd0, 13, ORG_ABS, 16'd1, 1'b0, 3'b000);
		op_item(OP_SEEK, 16'd0, 8, ORG_BEGIN, 16'd1, 1'b0, 3'b000);
		op_item(OP_SEEK, 16'd0, -3, ORG_CUR, 16'd1, 1'b0, 3'b000);
		op_item(OP_SEEK, 16'd0, -64, ORG_END, 16'd1, 1'b0, 3'b000);
		op_item(OP_READ, 16'd64, 0, ORG_ABS, 16'd1, 1'b0, 3'b000);
		op_item(OP_SEEK, 16'd0, -1, ORG_ABS, 16'd1, 1'b0, 3'b000);
		op_item(OP_SEEK, 16'd0, 1, ORG_END, 16'd1, 1'b0, 3'b111);
		op_item(OP_CLR, 16'd0, 0, ORG_ABS, 16'd1, 1'b0, 3'b000);
		op_item(OP_SEEK, 16'd0, 5, ORG_ABS, 16'd1, 1'b0, 3'b000);
		op_item(OP_ALIGN, 16'd0, 0, ORG_ABS, 16'd0, 1'b0, 3'b000);
		op_item(OP_ALIGN, 16'd0, 0, ORG_ABS, 16'd7, 1'b0, 3'b000);
		op_item(OP_ALIGN, 16'd0, 0, ORG_ABS, 16'hFFFF, 1'b0, 3'b000);
		op_item(OP_SEEK, 16'd0, 0, ORG_ABS, 16'd1, 1'b0, 3'b000);
		op_item(OP_UNGET, 16'd0, 0, ORG_ABS, 16'd1, 1'b0, 3'b000);
		op_item(OP_CLR, 16'd0, 0, ORG_ABS, 16'd1, 1'b0, 3'b000);
		op_item(OP_EXPECT, 16'd0, 0, ORG_ABS, 16'd1, 1'b0, 3'b000);
		op_item(OP_EXPECT, 16'd0, 0, ORG_ABS, 16'd1, 1'b1, 3'b000);
		op_item(OP_SET, 16'd0, 0, ORG_ABS, 16'd1, 1'b0, 3'b111);
		op_item(OP_ALIGN, 16'd0, 0, ORG_ABS, 16'd3, 1'b0, 3'b000);
		op_item(OP_UNUSED_LAST, 16'd0, 0, ORG_ABS, 16'd1, 1'b0, 3'b000);

		// Random phases over several windows, extremes and an inverted one included.
		// The windows above the store size read the filled bytes through wrap.
		for (int phase = 0; phase < 9; phase++) begin
			case (phase)
				0: begin lo = 0; hi = FILL_BYTES * 8; end
				1: begin lo = 0; hi = 0; end
				2: begin lo = 32768; hi = 32768; end
				3: begin lo = 100; hi = 2000; end
				4: begin lo = 3000; hi = 1000; end
				5: begin lo = 65535; hi = 65535; end
				6: begin
					lo = 32768 + int'($urandom_range(0, 1024));
					hi = lo + int'($urandom_range(0, 1024));
				end
				7: begin lo = 65536 - FILL_BYTES * 8; hi = 65535; end
				default: begin lo = 0; hi = FILL_BYTES * 8; end
			endcase
			set_window(lo, hi);
			idling_on = (phase < 8);
			op_item(OP_SEEK, 16'd0, 0, ORG_BEGIN, 16'd1, 1'b0, 3'b000);
			op_item(OP_CLR, 16'd0, 0, ORG_ABS, 16'd1, 1'b0, 3'b000);
			op_item(OP_READ, 16'd64, 0, ORG_ABS, 16'd1, 1'b0, 3'b000);
			op_item(OP_PEEK, 16'd0, 0, ORG_ABS, 16'd1, 1'b0, 3'b000);
			for (int k = 0; k < RANDOM_PER_PHASE; k++) random_item();
		end
		start <= 1'b0;

		// Drain the remaining results, then allow the block to settle.
		while (outstanding != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0 && outstanding == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end
endmodule

// ===== filelist.f =====
+incdir+src
src/bfr_pkg.sv
src/bfr_ctrl.sv
src/bfr_dp.sv
src/msb_first_bit_field_reader_top.sv
src/bfr_checker.sv
verif/msb_first_bit_field_reader_checker.sv
verif/msb_first_bit_field_reader_top_tb.sv
